@@ design/dpki_pkg.sv @@
// Package: shared types, constants and the algorithm table for the key-info parser.
`timescale 1ns / 1ps
package dpki_pkg;

    localparam int LENGTH_BITS   = 32;
    localparam int TABLE_ENTRIES = 4;
    localparam int ROWS          = 4;

    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_NOTDER  = 3'd3;
    localparam logic [2:0] ST_BER     = 3'd4;
    localparam logic [2:0] ST_BADTAG  = 3'd5;
    localparam logic [2:0] ST_UNKNOWN = 3'd6;
    localparam logic [2:0] ST_UNSUP   = 3'd7;

    localparam logic [1:0] ROLE_HDR  = 2'd0;
    localparam logic [1:0] ROLE_BODY = 2'd1;
    localparam logic [1:0] ROLE_DONE = 2'd2;
    localparam logic [1:0] ROLE_ERR  = 2'd3;

    localparam logic [7:0] TAG_SEQ  = 8'h30;
    localparam logic [7:0] TAG_OID  = 8'h06;
    localparam logic [7:0] TAG_NULL = 8'h05;
    localparam logic [7:0] TAG_OCT  = 8'h04;
    localparam logic [7:0] TAG_BIT  = 8'h03;
    localparam logic [7:0] TAG_INT  = 8'h02;
    localparam logic [7:0] LEN_LONG = 8'h80;
    localparam logic [7:0] LEN_RSVD = 8'hff;
    localparam logic [1:0] NO_NAME  = 2'd3;

    typedef enum logic [4:0] {
        P_OUTER_TAG, P_OUTER_LEN, P_SEQ_TAG, P_SEQ_LEN, P_OID_TAG, P_OID_LEN,
        P_OID_BODY, P_PARM_TAG, P_NULL_LEN, P_PARM_LEN, P_PARM_BODY, P_STR_TAG,
        P_STR_LEN, P_UNUSED, P_ELEM_TAG, P_ELEM_LEN, P_ELEM_BODY, P_DONE, P_ERROR
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] bytes_left;
        logic        buffer_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  byte_role;
        logic        element_start;
        logic [1:0]  element_name;
        logic [31:0] element_length;
        logic [1:0]  algorithm;
        logic [2:0]  status;
        logic        unused_bits_nonzero;
    } out_item_t;

    function automatic logic row_supported(input logic [1:0] r);
        return r != 2'd1;
    endfunction

    function automatic logic [1:0] row_algo(input logic [1:0] r);
        unique case (r)
            2'd2:    return 2'd1;
            2'd3:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [3:0] row_oidlen(input logic [1:0] r);
        unique case (r)
            2'd2:    return 4'd4;
            2'd3:    return 4'd7;
            default: return 4'd9;
        endcase
    endfunction

    function automatic logic [1:0] row_nelem(input logic [1:0] r);
        return (r == 2'd3) ? 2'd1 : 2'd3;
    endfunction

    function automatic logic [7:0] row_ctrl(input logic [1:0] r, input logic [1:0] e);
        if (r == 2'd3) return (e == 2'd0) ? TAG_INT : 8'h00;
        unique case (e)
            2'd0:    return TAG_SEQ;
            2'd1:    return TAG_INT;
            2'd2:    return TAG_INT;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [1:0] row_name(input logic [1:0] r, input logic [1:0] e);
        if (r == 2'd3) return (e == 2'd0) ? 2'd2 : NO_NAME;
        unique case (e)
            2'd1:    return 2'd0;
            2'd2:    return 2'd1;
            default: return NO_NAME;
        endcase
    endfunction

    // OID byte of a row at a position; valid flag false past the row's length
    function automatic logic [8:0] row_oid(input logic [1:0] r, input logic [3:0] p);
        logic [7:0] b;
        b = 8'h00;
        unique case (r)
            2'd0, 2'd1: begin
                unique case (p)
                    4'd0: b = 8'h2a; 4'd1: b = 8'h86; 4'd2: b = 8'h48;
                    4'd3: b = 8'h86; 4'd4: b = 8'hf7; 4'd5: b = 8'h0d;
                    4'd6: b = 8'h01; 4'd7: b = 8'h01;
                    4'd8: b = (r == 2'd0) ? 8'h01 : 8'h07;
                    default: b = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (p)
                    4'd0: b = 8'h55; 4'd1: b = 8'h08; 4'd2: b = 8'h01; 4'd3: b = 8'h01;
                    default: b = 8'h00;
                endcase
            end
            default: begin
                unique case (p)
                    4'd0: b = 8'h2a; 4'd1: b = 8'h86; 4'd2: b = 8'h48; 4'd3: b = 8'hce;
                    4'd4: b = 8'h38; 4'd5: b = 8'h04; 4'd6: b = 8'h01;
                    default: b = 8'h00;
                endcase
            end
        endcase
        return {p < row_oidlen(r), b};
    endfunction

endpackage

@@ design/dpki_core.sv @@
// Parse state and per-byte decode for the key-info parser.
`timescale 1ns / 1ps
module dpki_core
    import dpki_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result
);

    phase_t            phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [6:0]        pend_reg, pend_next;
    logic [31:0]       seqrem_reg, seqrem_next;
    logic [31:0]       cont_reg, cont_next;
    logic [ROWS-1:0]   cand_reg, cand_next;
    logic [3:0]        opos_reg, opos_next;
    logic [1:0]        aidx_reg, aidx_next;
    logic [1:0]        eidx_reg, eidx_next;
    logic              bits_reg, bits_next;
    logic [2:0]        stat_reg, stat_next;
    logic              warn_reg, warn_next;
    logic              aval_reg, aval_next;

    always_comb begin
        logic [7:0]  c;
        logic [31:0] left_after;
        logic [2:0]  err;
        logic        ldone;
        logic [1:0]  role;
        logic        estart;
        logic [1:0]  ename;
        logic [31:0] elen;
        logic [31:0] len32;
        logic [LENGTH_BITS-1:0] la;
        logic        found;
        logic [1:0]  fi;
        logic [1:0]  ei;
        logic [1:0]  en;
        logic [8:0]  ob;

        c = item.data_byte;
        left_after = (item.bytes_left != 32'd0) ? item.bytes_left - 32'd1 : 32'd0;
        phase_next = phase_reg; acc_next = acc_reg; pend_next = pend_reg;
        seqrem_next = seqrem_reg; cont_next = cont_reg; cand_next = cand_reg;
        opos_next = opos_reg; aidx_next = aidx_reg; eidx_next = eidx_reg;
        bits_next = bits_reg; stat_next = stat_reg; warn_next = warn_reg;
        aval_next = aval_reg;
        // restart on a new buffer
        if (item.buffer_start) begin
            phase_next = P_OUTER_TAG; acc_next = '0; pend_next = '0;
            seqrem_next = '0; cont_next = '0; cand_next = '1; opos_next = '0;
            aidx_next = '0; eidx_next = '0; bits_next = 1'b0; stat_next = ST_BUSY;
            warn_next = 1'b0; aval_next = 1'b0;
        end
        err = ST_BUSY; ldone = 1'b0; role = ROLE_HDR; estart = 1'b0;
        ename = 2'd0; elen = '0; found = 1'b0; fi = '0; len32 = '0;
        en = '0; ob = '0;
        ei = eidx_next;

        // length byte decode, shared by all length phases
        la = acc_next;
        if (pend_next == 7'd0) begin
            if (c == LEN_LONG) la = acc_next;
            else if (c[7]) la = '0;
            else la = LENGTH_BITS'(c);
        end else begin
            la = {acc_next[LENGTH_BITS-9:0], c};
        end

        unique case (phase_next)
            P_OUTER_LEN, P_SEQ_LEN, P_OID_LEN, P_PARM_LEN, P_STR_LEN, P_ELEM_LEN: begin
                if (pend_next == 7'd0) begin
                    if (c == LEN_LONG) err = ST_NOTDER;
                    else if (c == LEN_RSVD) err = ST_BER;
                    else if (c[7]) begin
                        acc_next = '0; pend_next = c[6:0];
                    end else begin
                        acc_next = la; ldone = 1'b1;
                    end
                end else begin
                    acc_next = la; pend_next = pend_next - 7'd1;
                    ldone = (pend_next == 7'd0);
                end
                if (err == ST_BUSY && ldone && {32'd0, acc_next} > {32'd0, left_after})
                    begin err = ST_INVALID; ldone = 1'b0; end
            end
            default: ;
        endcase
        len32 = 32'(acc_next);

        unique case (phase_next)
            P_OUTER_TAG, P_SEQ_TAG: begin
                if (c != TAG_SEQ) err = ST_BADTAG;
                else phase_next = phase_t'(phase_next + 5'd1);
            end
            P_OUTER_LEN: if (err == ST_BUSY && ldone) phase_next = P_SEQ_TAG;
            P_SEQ_LEN: begin
                if (err == ST_BUSY && ldone) begin
                    seqrem_next = len32; phase_next = P_OID_TAG;
                end
            end
            P_OID_TAG: begin
                if (c != TAG_OID) err = ST_BADTAG;
                else begin
                    if (seqrem_next == 0) err = ST_INVALID;
                    else seqrem_next = seqrem_next - 1;
                    phase_next = P_OID_LEN;
                end
            end
            P_OID_LEN: begin
                if (err == ST_BUSY) begin
                    if (seqrem_next == 0) err = ST_INVALID;
                    else seqrem_next = seqrem_next - 1;
                end
                if (err == ST_BUSY && ldone) begin
                    if (len32 > seqrem_next) err = ST_INVALID;
                    else begin
                        cont_next = len32;
                        for (int i = 0; i < ROWS; i++)
                            cand_next[i] = (i < TABLE_ENTRIES) &&
                                (len32 == 32'(row_oidlen(2'(i))));
                        opos_next = '0;
                        if (len32 == 0)
                            phase_next = (seqrem_next != 0) ? P_PARM_TAG : P_STR_TAG;
                        else phase_next = P_OID_BODY;
                    end
                end
            end
            P_OID_BODY: begin
                for (int i = 0; i < ROWS; i++) begin
                    ob = row_oid(2'(i), opos_next);
                    if (!ob[8] || ob[7:0] != c) cand_next[i] = 1'b0;
                end
                if (opos_next != 4'd15) opos_next = opos_next + 4'd1;
                if (seqrem_next != 0) seqrem_next = seqrem_next - 1;
                if (cont_next != 0) cont_next = cont_next - 1;
                if (cont_next == 0)
                    phase_next = (seqrem_next != 0) ? P_PARM_TAG : P_STR_TAG;
            end
            P_PARM_TAG: begin
                if (seqrem_next == 0) err = ST_INVALID;
                else seqrem_next = seqrem_next - 1;
                phase_next = (c == TAG_NULL) ? P_NULL_LEN : P_PARM_LEN;
            end
            P_NULL_LEN: begin
                if (c != 8'd0) err = ST_BER;
                else if (seqrem_next == 0) err = ST_INVALID;
                else begin
                    seqrem_next = seqrem_next - 1;
                    if (seqrem_next != 0) err = ST_INVALID;
                    else phase_next = P_STR_TAG;
                end
            end
            P_PARM_LEN: begin
                if (err == ST_BUSY) begin
                    if (seqrem_next == 0) err = ST_INVALID;
                    else seqrem_next = seqrem_next - 1;
                end
                if (err == ST_BUSY && ldone) begin
                    if (len32 != seqrem_next) err = ST_INVALID;
                    else begin
                        cont_next = len32;
                        phase_next = (len32 != 0) ? P_PARM_BODY : P_STR_TAG;
                    end
                end
            end
            P_PARM_BODY: begin
                if (seqrem_next != 0) seqrem_next = seqrem_next - 1;
                if (cont_next != 0) cont_next = cont_next - 1;
                if (cont_next == 0) phase_next = P_STR_TAG;
            end
            P_STR_TAG: begin
                if (c == TAG_BIT) begin bits_next = 1'b1; phase_next = P_STR_LEN; end
                else if (c == TAG_OCT) phase_next = P_STR_LEN;
                else err = ST_BADTAG;
            end
            P_STR_LEN: begin
                if (err == ST_BUSY && ldone) begin
                    // lowest candidate wins
                    for (int i = ROWS - 1; i >= 0; i--)
                        if (cand_next[i] && i < TABLE_ENTRIES) begin
                            found = 1'b1; fi = 2'(i);
                        end
                    if (!found) err = ST_UNKNOWN;
                    else if (!row_supported(fi)) err = ST_UNSUP;
                    else begin
                        aidx_next = fi; aval_next = 1'b1; eidx_next = '0;
                        phase_next = bits_next ? P_UNUSED : P_ELEM_TAG;
                    end
                end
            end
            P_UNUSED: begin
                if (c != 8'd0) warn_next = 1'b1;
                phase_next = P_ELEM_TAG;
            end
            P_ELEM_TAG: begin
                if (c != row_ctrl(aidx_next, ei)) err = ST_BADTAG;
                else phase_next = P_ELEM_LEN;
            end
            P_ELEM_LEN: begin
                if (err == ST_BUSY && ldone) begin
                    if (row_ctrl(aidx_next, ei) == TAG_INT &&
                        row_name(aidx_next, ei) != NO_NAME && len32 != 0) begin
                        estart = 1'b1; ename = row_name(aidx_next, ei); elen = len32;
                        cont_next = len32; phase_next = P_ELEM_BODY;
                    end else begin
                        if (row_ctrl(aidx_next, ei) == TAG_INT &&
                            row_name(aidx_next, ei) != NO_NAME) begin
                            estart = 1'b1; ename = row_name(aidx_next, ei); elen = len32;
                            cont_next = len32;
                        end
                        en = ei + 2'd1; eidx_next = en;
                        if (en >= row_nelem(aidx_next) || en == 2'd0) begin
                            phase_next = P_DONE; stat_next = ST_DONE;
                        end else phase_next = P_ELEM_TAG;
                    end
                end
            end
            P_ELEM_BODY: begin
                role = ROLE_BODY; ename = row_name(aidx_next, ei); elen = len32;
                if (cont_next != 0) cont_next = cont_next - 1;
                if (cont_next == 0) begin
                    en = ei + 2'd1; eidx_next = en;
                    if (en >= row_nelem(aidx_next) || en == 2'd0) begin
                        phase_next = P_DONE; stat_next = ST_DONE;
                    end else phase_next = P_ELEM_TAG;
                end
            end
            P_DONE:  role = ROLE_DONE;
            P_ERROR: role = ROLE_ERR;
            default: err = ST_INVALID;
        endcase

        // raise errors and truncation
        if (err != ST_BUSY) begin
            phase_next = P_ERROR; stat_next = err;
        end else if (role < ROLE_DONE && phase_next != P_DONE && item.bytes_left <= 32'd1) begin
            stat_next = (pend_next != 7'd0) ? ST_BER : ST_INVALID;
            phase_next = P_ERROR;
        end

        result.byte_role           = role;
        result.element_start       = estart;
        result.element_name        = ename;
        result.element_length      = elen;
        result.algorithm           = aval_next ? row_algo(aidx_next) : 2'd0;
        result.status              = stat_next;
        result.unused_bits_nonzero = warn_next;
    end

    // hold parse state; advance on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_OUTER_TAG; acc_reg <= '0; pend_reg <= '0;
            seqrem_reg <= '0; cont_reg <= '0; cand_reg <= '1; opos_reg <= '0;
            aidx_reg <= '0; eidx_reg <= '0; bits_reg <= 1'b0; stat_reg <= ST_BUSY;
            warn_reg <= 1'b0; aval_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next; acc_reg <= acc_next; pend_reg <= pend_next;
            seqrem_reg <= seqrem_next; cont_reg <= cont_next; cand_reg <= cand_next;
            opos_reg <= opos_next; aidx_reg <= aidx_next; eidx_reg <= eidx_next;
            bits_reg <= bits_next; stat_reg <= stat_next; warn_reg <= warn_next;
            aval_reg <= aval_next;
        end
    end

endmodule

@@ design/der_public_key_info_parser.sv @@
// Top level: input register, parse core and output register of the key-info parser.
// A byte's result reaches m_ through two registers: the input register, then the output one.
// Throughput: one byte per cycle unless m_tready stalls; one parse state step per byte.
// Reset: aresetn synchronous active low clears both stages and the parse state;
// the first byte after reset starts a record.
`timescale 1ns / 1ps
module der_public_key_info_parser
    import dpki_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // data_byte[7:0], bytes_left[39:8]
    input  logic        s_tuser,  // buffer_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // byte_role, element_start, element_name,
                                  // element_length, algorithm, status, unused_bits_nonzero
);

    logic      in_valid_reg;
    in_item_t  in_reg;
    logic      out_valid_reg;
    out_item_t out_reg;
    out_item_t core_result;
    logic      adv;

    // move the stage forward when the output slot is free or drains
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    dpki_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (adv),
        .item    (in_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (adv) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_reg.data_byte    <= s_tdata[7:0];
            in_reg.bytes_left   <= s_tdata[39:8];
            in_reg.buffer_start <= s_tuser;
        end
        if (adv) out_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.unused_bits_nonzero, out_reg.status, out_reg.algorithm,
                       out_reg.element_length, out_reg.element_name,
                       out_reg.element_start, out_reg.byte_role};

endmodule
